[rtl/core/bounded_list_table_engine_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the list engine RTL
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define BLTE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("list engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define BLTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list engine sequence check failed");

`endif

[rtl/core/blte_pkg.sv]
// ---------------------------------------------------------------------------
// blte_pkg
// Shared constants, command and status codes, and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package blte_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 4;
    localparam int POS_W     = 11;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_REM_AT  = 3'd3,
        CMD_REM_VAL = 3'd4,
        CMD_READ    = 3'd5,
        CMD_SORT    = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_PUT,
        S_REM_RD,
        S_REM_WR,
        S_SHRINK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_READ_OUT,
        S_SORT_RDA,
        S_SORT_RDB,
        S_SORT_CMP,
        S_SORT_SW1,
        S_SORT_SW2
    } t_state;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp_res;

endpackage

`default_nettype wire

[rtl/core/bounded_list_table_engine_unit.sv]
// ---------------------------------------------------------------------------
// bounded_list_table_engine_unit
// Ordered list of signed words with fill count and logical capacity.
// ---------------------------------------------------------------------------
// Clear, append and bad commands finish in the execute state; read adds a
// read-out state; insert/remove shift entries with one read and one write each;
// remove value reads and compares per probe; sort does read, read, compare, swap.
// All cost is set by the single memory port: one read or write per cycle.
// One item at a time; busy stays high until the result strobe is issued.
// Synchronous reset: idle, fill 0, capacity 4, register 4; memory untouched.
`default_nettype none

module bounded_list_table_engine_unit #(
    parameter int DEPTH = blte_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [blte_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [blte_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [blte_pkg::DATA_W-1:0] i_data_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [blte_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                                    o_done,
    output logic [blte_pkg::STAT_W-1:0]             o_status,
    output logic signed [blte_pkg::DATA_W-1:0]      o_read_data,
    output logic [blte_pkg::POS_W-1:0]              o_element_count,
    output logic [blte_pkg::POS_W-1:0]              o_logical_capacity
);

    `include "bounded_list_table_engine_unit_assert.svh"

    // Count width holds DEPTH itself; PW is wide enough for both counts and ports.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > blte_pkg::POS_W) ? CW : blte_pkg::POS_W;
    localparam int CAP_RST = (blte_pkg::CFG_RESET == 0) ? 1 :
                             ((blte_pkg::CFG_RESET > DEPTH) ? DEPTH : blte_pkg::CFG_RESET);

    blte_pkg::t_state r_state, n_state;

    logic [blte_pkg::CFG_W-1:0] r_cfg;
    logic [CW-1:0]              r_fill, n_fill;
    logic [CW-1:0]              r_cap, n_cap;
    logic [CW-1:0]              r_i, n_i;
    logic [CW-1:0]              r_j, n_j;
    logic [blte_pkg::CMD_W-1:0] r_cmd;
    logic [PW-1:0]              r_pos;
    logic signed [blte_pkg::DATA_W-1:0] r_val;
    logic signed [blte_pkg::DATA_W-1:0] r_a, n_a;
    logic signed [blte_pkg::DATA_W-1:0] r_b, n_b;
    logic                       r_done, n_done;
    logic [blte_pkg::STAT_W-1:0] r_status, n_status;
    logic signed [blte_pkg::DATA_W-1:0] r_rdout, n_rdout;

    // memory port
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic signed [blte_pkg::DATA_W-1:0] mem_wdata;
    logic signed [blte_pkg::DATA_W-1:0] mem_rdata;

    // shared comparator
    logic signed [blte_pkg::DATA_W-1:0] cmp_a;
    blte_pkg::t_cmp_res         cmp_res;

    logic                       accept;
    logic [PW-1:0]              fill_x, cap_x, cfg_x;
    logic [CW:0]                cap2;
    logic [CW-1:0]              cap_grown, cap_clr;
    logic [CW:0]                i_plus1, j_plus1, ij_plus1;
    logic [CW-1:0]              fill_dec;
    logic                       full;

    blte_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    blte_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (mem_rdata),
        .o_res (cmp_res)
    );

    assign busy   = (r_state != blte_pkg::S_IDLE);
    assign accept = start && !busy;

    assign fill_x   = PW'(r_fill);
    assign cap_x    = PW'(r_cap);
    assign cfg_x    = PW'(r_cfg);
    assign full     = (r_fill == CW'(DEPTH));
    assign fill_dec = r_fill - CW'(1);

    // Doubled capacity, clamped to the store depth.
    assign cap2      = {r_cap, 1'b0};
    assign cap_grown = (cap2 > (CW+1)'(DEPTH)) ? CW'(DEPTH) : cap2[CW-1:0];

    // Capacity loaded by clear, clamped to 1..DEPTH.
    always_comb begin
        if (cfg_x == '0) begin
            cap_clr = CW'(1);
        end else if (cfg_x > PW'(DEPTH)) begin
            cap_clr = CW'(DEPTH);
        end else begin
            cap_clr = cfg_x[CW-1:0];
        end
    end

    assign i_plus1  = {1'b0, r_i} + (CW+1)'(1);
    assign j_plus1  = {1'b0, r_j} + (CW+1)'(1);
    assign ij_plus1 = j_plus1 + {1'b0, r_i};

    // Sort compares the held left word; search compares the key.
    assign cmp_a = (r_state == blte_pkg::S_SORT_CMP) ? r_a : r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= blte_pkg::S_IDLE;
            r_cfg    <= blte_pkg::CFG_W'(blte_pkg::CFG_RESET);
            r_fill   <= '0;
            r_cap    <= CW'(CAP_RST);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cap    <= n_cap;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_a      <= n_a;
        r_b      <= n_b;
        r_status <= n_status;
        r_rdout  <= n_rdout;
        if (accept) begin
            r_cmd <= i_cmd;
            r_pos <= PW'(i_position);
            r_val <= i_data_word;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cap     = r_cap;
        n_i       = r_i;
        n_j       = r_j;
        n_a       = r_a;
        n_b       = r_b;
        n_done    = 1'b0;
        n_status  = r_status;
        n_rdout   = r_rdout;
        mem_we    = 1'b0;
        mem_addr  = r_i[AW-1:0];
        mem_wdata = r_val;

        unique case (r_state)
            blte_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = blte_pkg::S_EXEC;
                end
            end

            blte_pkg::S_EXEC: begin
                // Most paths finish here; long ones override below.
                n_status = blte_pkg::ST_OK;
                n_rdout  = '0;
                n_done   = 1'b1;
                n_state  = blte_pkg::S_IDLE;
                case (r_cmd)
                    blte_pkg::CMD_CLEAR: begin
                        n_fill = '0;
                        n_cap  = cap_clr;
                    end
                    blte_pkg::CMD_APPEND: begin
                        if (full) begin
                            n_status = blte_pkg::ST_FULL;
                        end else begin
                            if (r_fill >= r_cap) begin
                                n_cap = cap_grown;
                            end
                            mem_we   = 1'b1;
                            mem_addr = r_fill[AW-1:0];
                            n_fill   = r_fill + CW'(1);
                        end
                    end
                    blte_pkg::CMD_INSERT: begin
                        if (r_pos > fill_x) begin
                            n_status = blte_pkg::ST_BAD_INDEX;
                        end else if (full) begin
                            n_status = blte_pkg::ST_FULL;
                        end else begin
                            if (r_fill >= r_cap) begin
                                n_cap = cap_grown;
                            end
                            n_i     = r_fill;
                            n_done  = 1'b0;
                            n_state = blte_pkg::S_INS_RD;
                        end
                    end
                    blte_pkg::CMD_REM_AT: begin
                        if (r_pos >= fill_x) begin
                            n_status = blte_pkg::ST_BAD_INDEX;
                        end else begin
                            n_i     = r_pos[CW-1:0];
                            n_done  = 1'b0;
                            n_state = blte_pkg::S_REM_RD;
                        end
                    end
                    blte_pkg::CMD_REM_VAL: begin
                        n_i     = '0;
                        n_done  = 1'b0;
                        n_state = blte_pkg::S_SRCH_RD;
                    end
                    blte_pkg::CMD_READ: begin
                        if (r_pos >= fill_x) begin
                            n_status = blte_pkg::ST_BAD_INDEX;
                        end else begin
                            mem_addr = r_pos[AW-1:0];
                            n_done   = 1'b0;
                            n_state  = blte_pkg::S_READ_OUT;
                        end
                    end
                    blte_pkg::CMD_SORT: begin
                        // Fewer than two entries: already sorted.
                        if (r_fill > CW'(1)) begin
                            n_i     = '0;
                            n_j     = '0;
                            n_done  = 1'b0;
                            n_state = blte_pkg::S_SORT_RDA;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Shift up: move entry i-1 to i until the gap reaches the index.
            blte_pkg::S_INS_RD: begin
                if (r_i == r_pos[CW-1:0]) begin
                    n_state = blte_pkg::S_PUT;
                end else begin
                    mem_addr = r_i[AW-1:0] - AW'(1);
                    n_state  = blte_pkg::S_INS_WR;
                end
            end

            blte_pkg::S_INS_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_i       = r_i - CW'(1);
                n_state   = blte_pkg::S_INS_RD;
            end

            blte_pkg::S_PUT: begin
                mem_we   = 1'b1;
                mem_addr = r_pos[AW-1:0];
                n_fill   = r_fill + CW'(1);
                n_status = blte_pkg::ST_OK;
                n_rdout  = '0;
                n_done   = 1'b1;
                n_state  = blte_pkg::S_IDLE;
            end

            // Shift down: move entry i+1 to i up to the last entry.
            blte_pkg::S_REM_RD: begin
                if (i_plus1 >= {1'b0, r_fill}) begin
                    n_state = blte_pkg::S_SHRINK;
                end else begin
                    mem_addr = i_plus1[AW-1:0];
                    n_state  = blte_pkg::S_REM_WR;
                end
            end

            blte_pkg::S_REM_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_i       = i_plus1[CW-1:0];
                n_state   = blte_pkg::S_REM_RD;
            end

            // Drop one entry and halve the capacity when the list runs sparse.
            blte_pkg::S_SHRINK: begin
                n_fill = fill_dec;
                if ((fill_dec < (r_cap >> 2)) && (r_cap > CW'(2))) begin
                    n_cap = r_cap >> 1;
                end
                n_status = blte_pkg::ST_OK;
                n_rdout  = '0;
                n_done   = 1'b1;
                n_state  = blte_pkg::S_IDLE;
            end

            blte_pkg::S_SRCH_RD: begin
                if (r_i >= r_fill) begin
                    n_status = blte_pkg::ST_NOT_FOUND;
                    n_rdout  = '0;
                    n_done   = 1'b1;
                    n_state  = blte_pkg::S_IDLE;
                end else begin
                    n_state = blte_pkg::S_SRCH_CMP;
                end
            end

            blte_pkg::S_SRCH_CMP: begin
                if (cmp_res.eq) begin
                    n_state = blte_pkg::S_REM_RD;
                end else begin
                    n_i     = i_plus1[CW-1:0];
                    n_state = blte_pkg::S_SRCH_RD;
                end
            end

            blte_pkg::S_READ_OUT: begin
                n_status = blte_pkg::ST_OK;
                n_rdout  = mem_rdata;
                n_done   = 1'b1;
                n_state  = blte_pkg::S_IDLE;
            end

            // Bubble sort: i counts passes, j walks the unsorted prefix.
            blte_pkg::S_SORT_RDA: begin
                if (i_plus1 >= {1'b0, r_fill}) begin
                    n_status = blte_pkg::ST_OK;
                    n_rdout  = '0;
                    n_done   = 1'b1;
                    n_state  = blte_pkg::S_IDLE;
                end else if (ij_plus1 >= {1'b0, r_fill}) begin
                    n_i = i_plus1[CW-1:0];
                    n_j = '0;
                end else begin
                    mem_addr = r_j[AW-1:0];
                    n_state  = blte_pkg::S_SORT_RDB;
                end
            end

            blte_pkg::S_SORT_RDB: begin
                mem_addr = j_plus1[AW-1:0];
                n_a      = mem_rdata;
                n_state  = blte_pkg::S_SORT_CMP;
            end

            blte_pkg::S_SORT_CMP: begin
                mem_addr = r_j[AW-1:0];
                n_b      = mem_rdata;
                if (cmp_res.gt) begin
                    n_state = blte_pkg::S_SORT_SW1;
                end else begin
                    n_j     = j_plus1[CW-1:0];
                    n_state = blte_pkg::S_SORT_RDA;
                end
            end

            blte_pkg::S_SORT_SW1: begin
                mem_we    = 1'b1;
                mem_addr  = r_j[AW-1:0];
                mem_wdata = r_b;
                n_state   = blte_pkg::S_SORT_SW2;
            end

            blte_pkg::S_SORT_SW2: begin
                mem_we    = 1'b1;
                mem_addr  = j_plus1[AW-1:0];
                mem_wdata = r_a;
                n_j       = j_plus1[CW-1:0];
                n_state   = blte_pkg::S_SORT_RDA;
            end

            default: begin
                n_state = blte_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_read_data        = r_rdout;
    assign o_element_count    = fill_x[blte_pkg::POS_W-1:0];
    assign o_logical_capacity = cap_x[blte_pkg::POS_W-1:0];

    `BLTE_ASSERT_ALWAYS(a_fill_within_cap, r_fill <= r_cap)
    `BLTE_ASSERT_ALWAYS(a_cap_range, (r_cap != '0) && (r_cap <= CW'(DEPTH)))
    `BLTE_ASSERT_NEXT(a_accept_goes_busy, accept, busy)
    `BLTE_ASSERT_NEXT(a_done_single_pulse, r_done, !r_done)

endmodule

`default_nettype wire

[rtl/core/blte_store.sv]
// ---------------------------------------------------------------------------
// blte_store
// Single-port element memory with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module blte_store #(
    parameter int DEPTH = blte_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH)-1:0]          i_addr,
    input  wire logic signed [blte_pkg::DATA_W-1:0] i_wdata,
    output logic signed [blte_pkg::DATA_W-1:0]      o_rdata
);

    logic signed [blte_pkg::DATA_W-1:0] r_mem [DEPTH];

    // Write or read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/blte_cmp.sv]
// ---------------------------------------------------------------------------
// blte_cmp
// Shared word comparator: signed greater-than and equality.
// ---------------------------------------------------------------------------
`default_nettype none

module blte_cmp (
    input  wire logic signed [blte_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [blte_pkg::DATA_W-1:0] i_b,
    output blte_pkg::t_cmp_res                       o_res
);

    assign o_res.gt = (i_a > i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

`default_nettype wire

[test/tb_bounded_list_table_engine_unit.sv]
// ----------------------------------------------------------------------------
// List engine testbench
// Drives list commands (clear, append, insert, remove, search, read, sort)
// through the start/busy handshake in random bursts, predicts every result
// from a shadow copy of the list, and compares each result strobe against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_list_table_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = blte_pkg::DEPTH_DEF;
    localparam int CMD_W      = blte_pkg::CMD_W;
    localparam int POS_W      = blte_pkg::POS_W;
    localparam int DATA_W     = blte_pkg::DATA_W;
    localparam int STAT_W     = blte_pkg::STAT_W;
    localparam int CFG_W      = blte_pkg::CFG_W;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] word;
    } list_cmd_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] rdata;
        logic [POS_W-1:0]         count;
        logic [POS_W-1:0]         cap;
    } list_resp_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_cmd = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic signed [DATA_W-1:0]  i_data_word = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      o_done;
    logic [STAT_W-1:0]         o_status;
    logic signed [DATA_W-1:0]  o_read_data;
    logic [POS_W-1:0]          o_element_count;
    logic [POS_W-1:0]          o_logical_capacity;

    bounded_list_table_engine_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_position         (i_position),
        .i_data_word        (i_data_word),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_read_data        (o_read_data),
        .o_element_count    (o_element_count),
        .o_logical_capacity (o_logical_capacity)
    );

    always #1 i_clk = ~i_clk;

    // Shadow list state, kept in step with every accepted item
    logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int unsigned              shadow_fill = 0;
    int unsigned              shadow_cap = blte_pkg::CFG_RESET;
    int unsigned              shadow_init_cap = blte_pkg::CFG_RESET;

    list_cmd_t  pending_cmds [$];
    list_resp_t expected_resps [$];
    int         mismatch_count = 0;
    int         gen_fill = 0;
    longint     cycle_count = 0;

    function automatic int unsigned clamp_capacity(int unsigned c);
        if (c == 0) return 1;
        if (c > LIST_DEPTH) return LIST_DEPTH;
        return c;
    endfunction

    // Grow capacity before adding one element; 0 when the store is full.
    function automatic bit grow_for_one();
        if (shadow_fill >= LIST_DEPTH) return 0;
        if (shadow_fill >= shadow_cap) shadow_cap = clamp_capacity(shadow_cap * 2);
        return 1;
    endfunction

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < shadow_fill; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_fill--;
        if (shadow_fill < shadow_cap / 4 && shadow_cap > 2) shadow_cap = shadow_cap / 2;
    endfunction

    // Apply one command to the shadow list and queue the result it produces.
    function automatic void predict_list_step(list_cmd_t c);
        list_resp_t               r;
        int unsigned              i;
        logic signed [DATA_W-1:0] t;
        r.status = blte_pkg::ST_OK;
        r.rdata  = '0;
        case (c.cmd)
            blte_pkg::CMD_CLEAR: begin
                shadow_fill = 0;
                shadow_cap  = clamp_capacity(shadow_init_cap);
            end
            blte_pkg::CMD_APPEND: begin
                if (!grow_for_one()) r.status = blte_pkg::ST_FULL;
                else begin
                    shadow_list[shadow_fill] = c.word;
                    shadow_fill++;
                end
            end
            blte_pkg::CMD_INSERT: begin
                // index check comes first, then the full check
                if (c.pos > shadow_fill) r.status = blte_pkg::ST_BAD_INDEX;
                else if (!grow_for_one()) r.status = blte_pkg::ST_FULL;
                else begin
                    for (i = shadow_fill; i > c.pos; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[c.pos] = c.word;
                    shadow_fill++;
                end
            end
            blte_pkg::CMD_REM_AT: begin
                if (c.pos >= shadow_fill) r.status = blte_pkg::ST_BAD_INDEX;
                else drop_entry(c.pos);
            end
            blte_pkg::CMD_REM_VAL: begin
                for (i = 0; i < shadow_fill && shadow_list[i] != c.word; i++) ;
                if (i >= shadow_fill) r.status = blte_pkg::ST_NOT_FOUND;
                else drop_entry(i);
            end
            blte_pkg::CMD_READ: begin
                if (c.pos >= shadow_fill) r.status = blte_pkg::ST_BAD_INDEX;
                else r.rdata = shadow_list[c.pos];
            end
            blte_pkg::CMD_SORT: begin
                for (int unsigned a = 0; a + 1 < shadow_fill; a++)
                    for (int unsigned b = 0; b + 1 < shadow_fill - a; b++)
                        if (shadow_list[b] > shadow_list[b + 1]) begin
                            t = shadow_list[b];
                            shadow_list[b] = shadow_list[b + 1];
                            shadow_list[b + 1] = t;
                        end
            end
            default: ;  // unused code: no change
        endcase
        r.count = shadow_fill[POS_W-1:0];
        r.cap   = shadow_cap[POS_W-1:0];
        expected_resps.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold an item until accepted, then advance through bursts
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        list_cmd_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_list_step('{i_cmd, i_position, i_data_word});
            if (start && busy) begin
                // hold the item until the engine takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                i_cmd       <= nxt.cmd;
                i_position  <= nxt.pos;
                i_data_word <= nxt.word;
                start       <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest expected result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        list_resp_t e;
        if (i_rst_n && o_done) begin
            if (expected_resps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result strobe: status %0d", o_status);
            end else begin
                e = expected_resps.pop_front();
                if (o_status !== e.status || o_read_data !== e.rdata ||
                    o_element_count !== e.count || o_logical_capacity !== e.cap) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st %0d rd %0d cnt %0d cap %0d, ",
                                  "got st %0d rd %0d cnt %0d cap %0d"},
                                 e.status, e.rdata, e.count, e.cap,
                                 o_status, o_read_data, o_element_count, o_logical_capacity);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_cmd(logic [CMD_W-1:0] c, int unsigned p, logic signed [DATA_W-1:0] w);
        pending_cmds.push_back('{c, p[POS_W-1:0], w});
    endtask

    // Wait until every queued item is taken and every result has arrived.
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_resps.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the capacity register; the engine is idle here.
    task automatic write_capacity(logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        shadow_init_cap = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 7);  // small pool so searches hit
        endcase
    endfunction

    // Random phase: mostly valid list traffic, kept short so sorts stay cheap.
    task automatic random_phase(int n);
        int unsigned sel;
        int unsigned p;
        push_cmd(blte_pkg::CMD_CLEAR, 0, 0);
        gen_fill = 0;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, gen_fill);
            if (gen_fill > 40 && sel < 45) sel = sel + 45;  // lean toward removal
            if (sel < 25) begin
                push_cmd(blte_pkg::CMD_APPEND, 0, pick_word());
                gen_fill++;
            end else if (sel < 45) begin
                push_cmd(blte_pkg::CMD_INSERT, p, pick_word());
                if (p <= gen_fill) gen_fill++;
            end else if (sel < 62) begin
                push_cmd(blte_pkg::CMD_REM_AT, p, pick_word());
                if (p < gen_fill) gen_fill--;
            end else if (sel < 74) begin
                push_cmd(blte_pkg::CMD_REM_VAL, p, pick_word());
            end else if (sel < 90) begin
                push_cmd(blte_pkg::CMD_READ, p, pick_word());
            end else if (sel < 96) begin
                push_cmd(blte_pkg::CMD_SORT, p, pick_word());
            end else if (sel < 98) begin
                push_cmd(CMD_UNUSED, p, pick_word());
            end else begin
                push_cmd(blte_pkg::CMD_CLEAR, p, pick_word());
                gen_fill = 0;
            end
        end
        drain();
    endtask

    initial begin
        logic [CFG_W-1:0] cap_settings [7];
        cap_settings = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd1024, 11'd2047, 11'd0};
        cap_settings[6] = $urandom_range(4, 64);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list errors, extremes, growth, bad indexes, shrink
        push_cmd(blte_pkg::CMD_READ, 0, 0);
        push_cmd(blte_pkg::CMD_REM_AT, 0, 0);
        push_cmd(blte_pkg::CMD_REM_VAL, 0, 32'sd5);
        push_cmd(blte_pkg::CMD_SORT, 0, 0);
        push_cmd(CMD_UNUSED, 2047, 32'sh8000_0000);
        push_cmd(blte_pkg::CMD_APPEND, 0, 32'sh7FFF_FFFF);
        push_cmd(blte_pkg::CMD_APPEND, 0, 32'sh8000_0000);
        push_cmd(blte_pkg::CMD_APPEND, 0, 0);
        push_cmd(blte_pkg::CMD_APPEND, 0, -1);
        push_cmd(blte_pkg::CMD_APPEND, 0, 32'sd5);           // grows capacity 4 -> 8
        push_cmd(blte_pkg::CMD_INSERT, 0, 32'sd9);
        push_cmd(blte_pkg::CMD_INSERT, 6, 32'sd3);           // insert at the end
        push_cmd(blte_pkg::CMD_INSERT, 8, 32'sd1);           // one past the end
        push_cmd(blte_pkg::CMD_INSERT, 2047, 32'sd1);
        push_cmd(blte_pkg::CMD_READ, 6, 0);
        push_cmd(blte_pkg::CMD_READ, 7, 0);
        push_cmd(blte_pkg::CMD_SORT, 0, 0);
        push_cmd(blte_pkg::CMD_READ, 0, 0);
        push_cmd(blte_pkg::CMD_READ, 6, 0);
        push_cmd(blte_pkg::CMD_REM_VAL, 0, -1);
        for (int k = 0; k < 5; k++) push_cmd(blte_pkg::CMD_REM_AT, 0, 0);  // shrink 8 -> 4
        push_cmd(blte_pkg::CMD_CLEAR, 0, 0);
        drain();

        foreach (cap_settings[s]) begin
            write_capacity(cap_settings[s]);
            random_phase(78);
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
